// ===== hw/rtl/jse_pkg.sv =====
// Package for the JSON string escaper.
// Shared widths, register map, queue defaults and the front-to-back command type.
// No dependencies.
`default_nettype none

package jse_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned PIECE_MAX   = 6;
  localparam int unsigned PIECE_IDX_W = 3;
  localparam int unsigned SEQ_MAX     = 4;
  localparam int unsigned SEQ_CNT_W   = 3;

  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic        REG_OUT_CAPACITY = 1'b0;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 48;

  typedef struct packed {
    logic [PIECE_MAX-1:0][BYTE_W-1:0] bytes;
    logic [PIECE_IDX_W-1:0]           nbytes;
    logic                             term;
    logic                             term_valid;
    logic [LEN_W-1:0]                 req;
    logic                             trunc;
  } esc_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/json_string_escaper.sv =====
// JSON string escaper, top level: APB capacity register, front, queue, back.
// Depends on jse_pkg, jse_front, jse_queue, jse_back.
//
// Input stream (s_*): one UTF-8 byte per transaction. s_tdata carries the
// byte, s_tuser says the byte is present (0 with s_tlast 1 is an empty end
// marker), s_tlast closes the string. Output stream (m_*): one escaped byte
// per transaction; the final transaction of a string has m_tlast set, carries
// the NUL terminator (m_tuser 1 only if capacity allowed it), the required
// length and the truncated flag.
// out_capacity (APB, address 0) is sampled when a string opens; write it
// only between strings.
// The first result of an item is registered in the queue entry and then in
// the back part's output register. Input is taken one item per cycle; the
// output port moves one byte per cycle while m_tready is high, so an item
// of k bytes (up to 7) holds the back part. A QUEUE_DEPTH-entry command queue
// absorbs that; s_tready drops only while the queue is full.
// A stalled m_tready holds the output register and fills the queue.
// Reset clears all string state and the capacity register to zero.
`default_nettype none

module json_string_escaper
  import jse_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
  input  wire logic                  s_tuser,   // [0] has_byte
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [39:8] required_length,
                                                // [40] truncated, [47:41] zero
  output logic                       m_tuser,   // [0] byte_valid
  output logic                       m_tlast
);

  logic [LEN_W-1:0]  out_capacity;
  logic              cfg_wr;
  logic              push_valid;
  logic              push_ready;
  esc_cmd_t          push_cmd;
  logic              pop_valid;
  logic              pop;
  esc_cmd_t          pop_cmd;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  required_length;
  logic              truncated;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_OUT_CAPACITY);
  assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? out_capacity : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= '0;
    end else if (cfg_wr) begin
      out_capacity <= pwdata;
    end
  end

  jse_front u_front (
    .clk           (clk),
    .rst           (rst),
    .capacity      (out_capacity),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .data_byte     (s_tdata[7:0]),
    .has_byte      (s_tuser),
    .end_of_string (s_tlast),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  jse_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (pop_valid),
    .cmd             (pop_cmd),
    .pop             (pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_byte        (out_byte),
    .byte_valid      (m_tuser),
    .is_last         (m_tlast),
    .required_length (required_length),
    .truncated       (truncated)
  );

  assign m_tdata = {7'd0, truncated, required_length, out_byte};

  // data bytes carry no length or truncation info and are always written
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser && required_length == '0 && !truncated)
    else $error("data transaction with status fields set");

  // terminator is a NUL byte
  a_term_nul: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> out_byte == '0)
    else $error("terminator byte is not zero");

  // a truncated string needed more than the capacity it was given
  a_trunc_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && truncated |->
      (required_length > out_capacity) || (required_length == '1))
    else $error("truncated string with required length within capacity");

endmodule

`default_nettype wire

// ===== hw/rtl/jse_front.sv =====
// Front part of the JSON string escaper: gathers UTF-8 sequences, classifies
// bytes, does the space and length bookkeeping and pushes commands to the queue.
// Depends on jse_pkg.
`default_nettype none

module jse_front
  import jse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [LEN_W-1:0]  capacity,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              has_byte,
  input  wire logic              end_of_string,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output esc_cmd_t               push_cmd
);

  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'h0c;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6e;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      hex_digit = CH_ZERO + {4'd0, v};
    end else begin
      hex_digit = 8'h61 + {4'd0, v - 4'd10};
    end
  endfunction

  logic                            open;
  logic [LEN_W-1:0]                space_left;
  logic                            space_exhausted;
  logic [LEN_W-1:0]                needed_count;
  logic [SEQ_CNT_W-1:0]            seq_count;
  logic [SEQ_CNT_W-1:0]            seq_expected;
  logic [SEQ_MAX-1:0][BYTE_W-1:0]  seq_bytes;

  logic                            accept;
  logic                            active;
  logic [LEN_W-1:0]                cur_space;
  logic                            cur_exh;
  logic [LEN_W-1:0]                cur_need;
  logic [SEQ_CNT_W-1:0]            cur_cnt;
  logic [SEQ_CNT_W-1:0]            cur_exp;
  logic                            is_cont;
  logic                            cont;
  logic                            fresh;
  logic                            ascii;
  logic                            lead;
  logic                            raw;
  logic [SEQ_CNT_W-1:0]            lead_len;
  logic [1:0]                      wr_idx;
  logic                            seq_wr;
  logic [SEQ_MAX-1:0][BYTE_W-1:0]  seq_w;
  logic [SEQ_CNT_W-1:0]            cnt_w;
  logic [SEQ_CNT_W-1:0]            exp_w;
  logic                            seq_piece;
  logic [BYTE_W-1:0]               esc_code;
  logic [PIECE_MAX-1:0][BYTE_W-1:0] piece;
  logic [PIECE_IDX_W-1:0]          piece_n;
  logic                            has_piece;
  logic                            fail;
  logic                            write;
  logic [LEN_W-1:0]                space_next;
  logic                            exh_next;
  logic [LEN_W:0]                  need_sum;
  logic [LEN_W-1:0]                need_next;

  assign in_ready = push_ready;
  assign accept   = in_valid & in_ready;
  assign active   = accept & (has_byte | end_of_string);

  assign cur_space = open ? space_left      : capacity;
  assign cur_exh   = open ? space_exhausted : 1'b0;
  assign cur_need  = open ? needed_count    : '0;
  assign cur_cnt   = open ? seq_count       : '0;
  assign cur_exp   = open ? seq_expected    : '0;

  assign is_cont = (data_byte[7:6] == 2'b10);
  assign cont    = has_byte & (cur_cnt != '0) & is_cont;
  assign fresh   = has_byte & ~cont;
  assign ascii   = fresh & (data_byte < 8'h80);
  assign lead    = fresh & (data_byte >= 8'hc0) & (data_byte <= 8'hf7);
  assign raw     = fresh & ~ascii & ~lead;

  always_comb begin
    if (data_byte < 8'he0) begin
      lead_len = 3'd2;
    end else if (data_byte < 8'hf0) begin
      lead_len = 3'd3;
    end else begin
      lead_len = 3'd4;
    end
  end

  assign wr_idx = cont ? cur_cnt[1:0] : 2'd0;
  assign seq_wr = cont | lead;

  always_comb begin
    for (int i = 0; i < SEQ_MAX; i++) begin
      seq_w[i] = (seq_wr && (wr_idx == 2'(i))) ? data_byte : seq_bytes[i];
    end
  end

  always_comb begin
    if (!has_byte) begin
      cnt_w = cur_cnt;
      exp_w = cur_exp;
    end else if (cont) begin
      cnt_w = cur_cnt + 3'd1;
      exp_w = cur_exp;
    end else if (lead) begin
      cnt_w = 3'd1;
      exp_w = lead_len;
    end else begin
      cnt_w = '0;
      exp_w = '0;
    end
  end

  assign seq_piece = (cont && (cnt_w >= exp_w)) || (end_of_string && (cnt_w != '0));

  always_comb begin
    case (data_byte)
      CH_QUOTE:  esc_code = CH_QUOTE;
      CH_BSLASH: esc_code = CH_BSLASH;
      CH_BS:     esc_code = CH_B;
      CH_FF:     esc_code = CH_F;
      CH_LF:     esc_code = CH_N;
      CH_CR:     esc_code = CH_R;
      CH_TAB:    esc_code = CH_T;
      default:   esc_code = '0;
    endcase
  end

  always_comb begin
    piece   = '0;
    piece_n = '0;
    if (seq_piece) begin
      for (int i = 0; i < SEQ_MAX; i++) begin
        piece[i] = seq_w[i];
      end
      piece_n = cnt_w;
    end else if (ascii) begin
      if (esc_code != '0) begin
        piece[0] = CH_BSLASH;
        piece[1] = esc_code;
        piece_n  = 3'd2;
      end else if ((data_byte < CH_SPACE) || (data_byte == CH_DEL)) begin
        piece[0] = CH_BSLASH;
        piece[1] = CH_U;
        piece[2] = CH_ZERO;
        piece[3] = CH_ZERO;
        piece[4] = hex_digit(data_byte[7:4]);
        piece[5] = hex_digit(data_byte[3:0]);
        piece_n  = 3'd6;
      end else begin
        piece[0] = data_byte;
        piece_n  = 3'd1;
      end
    end else if (raw) begin
      piece[0] = data_byte;
      piece_n  = 3'd1;
    end
  end

  assign has_piece  = (piece_n != '0);
  assign fail       = has_piece & (cur_exh | (cur_space <= LEN_W'(piece_n)));
  assign write      = has_piece & ~fail;
  assign space_next = write ? cur_space - LEN_W'(piece_n) : cur_space;
  assign exh_next   = cur_exh | fail;
  assign need_sum   = {1'b0, cur_need} + (LEN_W+1)'(piece_n) + (LEN_W+1)'(end_of_string);
  assign need_next  = need_sum[LEN_W] ? '1 : need_sum[LEN_W-1:0];

  assign push_valid = active & (write | end_of_string);

  always_comb begin
    push_cmd            = '0;
    push_cmd.bytes      = piece;
    push_cmd.nbytes     = write ? piece_n : '0;
    push_cmd.term       = end_of_string;
    push_cmd.term_valid = (space_next != '0);
    push_cmd.req        = end_of_string ? need_next : '0;
    push_cmd.trunc      = end_of_string & exh_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open            <= 1'b0;
      space_left      <= '0;
      space_exhausted <= 1'b0;
      needed_count    <= '0;
      seq_count       <= '0;
      seq_expected    <= '0;
    end else if (active) begin
      if (end_of_string) begin
        open            <= 1'b0;
        space_exhausted <= 1'b0;
        needed_count    <= '0;
        seq_count       <= '0;
        seq_expected    <= '0;
      end else begin
        open            <= 1'b1;
        space_left      <= space_next;
        space_exhausted <= exh_next;
        needed_count    <= need_next;
        seq_count       <= seq_piece ? '0 : cnt_w;
        seq_expected    <= seq_piece ? '0 : exp_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      seq_bytes <= seq_w;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jse_queue.sv =====
// Command queue between the front and back parts of the JSON string escaper.
// Small register-file FIFO with occupancy count; depends on jse_pkg.
`default_nettype none

module jse_queue
  import jse_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire esc_cmd_t push_cmd,
  output logic          pop_valid,
  input  wire logic     pop,
  output esc_cmd_t      pop_cmd
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  esc_cmd_t        entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jse_back.sv =====
// Back part of the JSON string escaper (depends on jse_pkg): walks each queued
// command and emits one byte per cycle unless stalled, through an output register.
`default_nettype none

module jse_back
  import jse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cmd_valid,
  input  wire esc_cmd_t cmd,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic          byte_valid,
  output logic          is_last,
  output logic [LEN_W-1:0] required_length,
  output logic          truncated
);

  logic [PIECE_IDX_W-1:0] idx;
  logic [PIECE_IDX_W-1:0] total;
  logic                   load;
  logic                   step;
  logic                   last_el;
  logic                   at_term;

  assign load    = ~out_valid | out_ready;
  assign step    = load & cmd_valid;
  assign total   = cmd.nbytes + PIECE_IDX_W'(cmd.term);
  assign last_el = (idx == total - 1'b1);
  assign at_term = (idx >= cmd.nbytes);
  assign pop     = step & last_el;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (step) begin
      out_valid <= 1'b1;
      idx       <= last_el ? '0 : idx + 1'b1;
    end else if (load) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (at_term) begin
        out_byte        <= '0;
        byte_valid      <= cmd.term_valid;
        is_last         <= 1'b1;
        required_length <= cmd.req;
        truncated       <= cmd.trunc;
      end else begin
        out_byte        <= cmd.bytes[idx];
        byte_valid      <= 1'b1;
        is_last         <= 1'b0;
        required_length <= '0;
        truncated       <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_json_string_escaper.sv =====
// Testbench for json_string_escaper: directed table, then random UTF-8 strings in phases
// of output capacity, checked against an in-bench escaping predictor.
// Depends on jse_pkg and the json_string_escaper RTL.
module tb_json_string_escaper
  import jse_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        is_last;
    logic [31:0] req_len;
    logic        trunc;
  } esc_out_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } item_t;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] val;
    logic        has;
    logic        eos;
    logic        typed;
    esc_out_t    res;
  } row_t;

  localparam logic [APB_ADDR_W-1:0] CAP_ADDR = {REG_OUT_CAPACITY, 2'b00};
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] ESC_SET [7] = '{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR,
                                         CH_TAB};
  localparam esc_out_t NO_RES = '0;

  localparam int PLAN_N = 27;
  localparam row_t PLAN [PLAN_N] = '{
    '{ROW_ITEM, 32'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 32'd1, 1'b0}},
    '{ROW_ITEM, 32'h41, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 32'd2, 1'b1}},
    '{ROW_CAP, 32'hffffffff, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h00, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'hff, 1'b1, 1'b0, 1'b1, '{8'hff, 1'b1, 1'b0, 32'd0, 1'b0}},
    '{ROW_ITEM, 32'(CH_QUOTE), 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'(CH_BSLASH), 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'(CH_BS), 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'(CH_FF), 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'(CH_LF), 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'(CH_CR), 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'(CH_TAB), 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h1f, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'(CH_DEL), 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h7e, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'hc3, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'ha9, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h80, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'he2, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h41, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'hf0, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h9f, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h98, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h80, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'hf4, 1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 32'h8f, 1'b1, 1'b1, 1'b0, NO_RES}
  };

  localparam int PHASES      = 9;
  localparam int HOLD_PHASE  = 2;
  localparam int RAND_PHASE  = 5;
  localparam int HOLD_CYCLES = 64;
  localparam logic [31:0] PHASE_CAP [PHASES] = '{32'd1, 32'd2, 32'hffffffff, 32'd7, 32'd24,
                                                 32'd0, 32'h80000000, 32'd0, 32'h0000ffff};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid, s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tuser, s_tlast;
  logic                  m_tvalid, m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser, m_tlast;

  json_string_escaper u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  esc_out_t    escaped_q[$];
  esc_out_t    fresh_q[$];
  logic [31:0] cap_reg, room_left, need_len;
  logic        room_gone, str_open;
  logic [7:0]  seq_buf [4];
  int unsigned seq_want, seq_have;

  int unsigned mismatches = 0;
  int unsigned items_done = 0;
  bit          gaps_on = 1'b1;
  bit          rx_stall_on = 1'b1;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;

  function automatic void put_out(logic [7:0] b);
    fresh_q.push_back('{b, 1'b1, 1'b0, 32'd0, 1'b0});
  endfunction

  function automatic void add_need(logic [31:0] n);
    if (need_len > 32'hffffffff - n) need_len = 32'hffffffff;
    else need_len = need_len + n;
  endfunction

  function automatic bit claim(logic [31:0] n);
    add_need(n);
    if (room_gone) return 1'b0;
    if (room_left <= n) begin
      room_gone = 1'b1;
      return 1'b0;
    end
    room_left = room_left - n;
    return 1'b1;
  endfunction

  function automatic void flush_seq();
    if (claim(seq_have)) begin
      for (int i = 0; i < seq_have; i++) put_out(seq_buf[i]);
    end
    seq_have = 0;
    seq_want = 0;
  endfunction

  function automatic logic [7:0] hex_nib(logic [3:0] v);
    return (v < 10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    logic [7:0] e;
    if (seq_have != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_buf[seq_have[1:0]] = b;
        seq_have++;
        if (seq_have >= seq_want) flush_seq();
        return;
      end
      seq_have = 0;
      seq_want = 0;
    end
    if (b < 8'h80) begin
      case (b)
        CH_QUOTE:  e = CH_QUOTE;
        CH_BSLASH: e = CH_BSLASH;
        CH_BS:     e = "b";
        CH_FF:     e = "f";
        CH_LF:     e = "n";
        CH_CR:     e = "r";
        CH_TAB:    e = "t";
        default:   e = 8'h00;
      endcase
      if (e != 8'h00) begin
        if (claim(2)) begin
          put_out(CH_BSLASH);
          put_out(e);
        end
      end else if (b < 8'h20 || b == CH_DEL) begin
        if (claim(6)) begin
          put_out(CH_BSLASH);
          put_out("u");
          put_out("0");
          put_out("0");
          put_out(hex_nib(b[7:4]));
          put_out(hex_nib(b[3:0]));
        end
      end else if (claim(1)) begin
        put_out(b);
      end
    end else if (b >= 8'hc0 && b <= 8'hf7) begin
      seq_buf[0] = b;
      seq_have = 1;
      seq_want = (b < 8'he0) ? 2 : (b < 8'hf0) ? 3 : 4;
    end else if (claim(1)) begin
      put_out(b);
    end
  endfunction

  function automatic void escape_item(item_t it);
    if (!it.has && !it.eos) return;
    if (!str_open) begin
      str_open = 1'b1;
      room_left = cap_reg;
      room_gone = 1'b0;
      need_len = 32'd0;
      seq_have = 0;
      seq_want = 0;
    end
    if (it.has) take_byte(it.data);
    if (it.eos) begin
      if (seq_have != 0) flush_seq();
      add_need(1);
      fresh_q.push_back('{8'h00, room_left > 0, 1'b1, need_len, room_gone});
      str_open = 1'b0;
      seq_have = 0;
      seq_want = 0;
      room_gone = 1'b0;
      need_len = 32'd0;
    end
  endfunction

  task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t: %s expected %h got %h", $time, name, want, got);
  endtask

  // output checker
  always @(posedge clk) begin
    esc_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tuser, m_tlast, m_tdata[39:8], m_tdata[40]};
      if (escaped_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none got %h", $time, got);
      end else begin
        want = escaped_q.pop_front();
        if (got.out_byte !== want.out_byte) flag_field("out_byte", want.out_byte, got.out_byte);
        if (got.byte_valid !== want.byte_valid)
          flag_field("byte_valid", want.byte_valid, got.byte_valid);
        if (got.is_last !== want.is_last) flag_field("is_last", want.is_last, got.is_last);
        if (got.req_len !== want.req_len)
          flag_field("required_length", want.req_len, got.req_len);
        if (got.trunc !== want.trunc) flag_field("truncated", want.trunc, got.trunc);
      end
    end
  end

  // output side: random stalls plus one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (rx_stall_on && !calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic feed(item_t it, bit typed = 1'b0, esc_out_t typed_res = '0);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.data;
    s_tuser  <= it.has;
    s_tlast  <= it.eos;
    do @(posedge clk); while (!s_tready);
    fresh_q.delete();
    escape_item(it);
    if (typed) escaped_q.push_back(typed_res);
    else foreach (fresh_q[i]) escaped_q.push_back(fresh_q[i]);
    if (it.has || it.eos) items_done++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (escaped_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_capacity(logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) flag_field("out_capacity", v, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic item_t byte_item(logic [7:0] b);
    return '{b, 1'b1, 1'b0};
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  task automatic send_string();
    item_t       parts[$];
    int unsigned n_chars, pick, cont_n;
    logic [7:0]  lead;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        parts.push_back(byte_item(8'($urandom_range(8'h20, 8'h7e))));
      end else if (pick < 50) begin
        parts.push_back(byte_item(ESC_SET[$urandom_range(0, 6)]));
      end else if (pick < 60) begin
        parts.push_back(byte_item(($urandom_range(0, 32) == 32) ? CH_DEL
                                                                 : 8'($urandom_range(0, 31))));
      end else if (pick < 85) begin
        cont_n = (pick < 70) ? 1 : (pick < 78) ? 2 : 3;
        lead = (cont_n == 1) ? 8'($urandom_range(8'hc0, 8'hdf))
             : (cont_n == 2) ? 8'($urandom_range(8'he0, 8'hef))
             : 8'($urandom_range(8'hf0, 8'hf7));
        parts.push_back(byte_item(lead));
        repeat (cont_n) parts.push_back(byte_item(cont_byte()));
      end else if (pick < 90) begin
        parts.push_back(byte_item($urandom_range(0, 1) ? cont_byte()
                                                        : 8'($urandom_range(8'hf8, 8'hff))));
      end else if (pick < 95) begin
        // sequence cut short by a fresh byte
        parts.push_back(byte_item(8'($urandom_range(8'he0, 8'hf7))));
        repeat ($urandom_range(0, 1)) parts.push_back(byte_item(cont_byte()));
        parts.push_back(byte_item($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7f))
                                                        : 8'($urandom_range(8'hc0, 8'hff))));
      end else begin
        parts.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
      end
    end
    if (parts.size() != 0 && parts[parts.size()-1].has && $urandom_range(0, 1) == 1)
      parts[parts.size()-1].eos = 1'b1;
    else
      parts.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
    foreach (parts[i]) feed(parts[i]);
  endtask

  initial begin
    int unsigned phase_start;
    logic [31:0] cap;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    cap_reg = '0;
    room_left = '0;
    need_len = '0;
    room_gone = 1'b0;
    str_open = 1'b0;
    seq_have = 0;
    seq_want = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_CAP) begin
        drain();
        set_capacity(PLAN[r].val);
      end else begin
        feed('{PLAN[r].val[7:0], PLAN[r].has, PLAN[r].eos}, PLAN[r].typed, PLAN[r].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      cap = (p == RAND_PHASE) ? 32'($urandom_range(3, 60)) : PHASE_CAP[p];
      set_capacity(cap);
      calm = (p == PHASES - 1);
      gaps_on = !calm && p != HOLD_PHASE && $urandom_range(0, 3) != 0;
      rx_stall_on = !calm && $urandom_range(0, 3) != 0;
      if (p == HOLD_PHASE) long_hold_req = 1'b1;
      phase_start = items_done;
      while (items_done - phase_start < 40) send_string();
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && escaped_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
